// ===== rtl/core/csa_pkg.sv =====
// csa_pkg: shared types and codes for the connection slot allocator
// no dependencies; imported by the interfaces and every module of the block

package csa_pkg;

    localparam int unsigned SIZE_W   = 7;   // table size, counts, config registers
    localparam int unsigned FUNC_W   = 3;
    localparam int unsigned SID_W    = 6;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CFG_IDX_W = 1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_QUERY   = 3'd0,
        FUNC_ALLOC   = 3'd1,
        FUNC_RELEASE = 3'd2,
        FUNC_CLEAR   = 3'd3,
        FUNC_INIT    = 3'd4
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_EXHAUSTED  = 2'd1,
        STAT_RANGE      = 2'd2,
        STAT_BAD_CONFIG = 2'd3
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLOTS     = 1'd1;

    localparam logic [SIZE_W-1:0] INITIAL_COUNT_RST = 7'd1;
    localparam logic [SIZE_W-1:0] MAX_SLOTS_RST     = 7'd64;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the incoming item
        logic execute;   // apply the latched item and register its result
    } csa_cmd_t;

    typedef struct packed {
        logic                granted;
        logic [SID_W-1:0]    slot_index;
        logic                slot_active;
        logic                slot_exists;
        logic [SIZE_W-1:0]   free_count;
        logic                pool_full;
        logic [SIZE_W-1:0]   table_size;
        logic [STATUS_W-1:0] status;
    } csa_result_t;

endpackage

// ===== rtl/core/csa_channels.sv =====
// csa_channels: valid/ready channel interfaces for requests and responses
// depends on csa_pkg

interface csa_req_if;
    import csa_pkg::*;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [SID_W-1:0]  slot_id;

    modport source (output valid, func, slot_id, input ready);
    modport sink   (input valid, func, slot_id, output ready);
endinterface

interface csa_rsp_if;
    import csa_pkg::*;
    logic                valid;
    logic                ready;
    logic                granted;
    logic [SID_W-1:0]    slot_index;
    logic                slot_active;
    logic                slot_exists;
    logic [SIZE_W-1:0]   free_count;
    logic                pool_full;
    logic [SIZE_W-1:0]   table_size;
    logic [STATUS_W-1:0] status;

    modport source (output valid, granted, slot_index, slot_active, slot_exists,
                    free_count, pool_full, table_size, status, input ready);
    modport sink   (input valid, granted, slot_index, slot_active, slot_exists,
                    free_count, pool_full, table_size, status, output ready);
endinterface

// ===== rtl/core/csa_ctrl.sv =====
// csa_ctrl: sequencing state machine, one item in flight at a time
// depends on csa_pkg; drives csa_dp through csa_cmd_t

module csa_ctrl
    import csa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output csa_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;
    logic   out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg    <= S_EXEC;
                        in_ready_reg <= 1'b0;
                    end
                end
                S_EXEC:
                begin
                    state_reg     <= S_DONE;
                    out_valid_reg <= 1'b1;
                end
                S_DONE:
                begin
                    if (out_ready)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b0;
                        in_ready_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg     <= S_IDLE;
                    in_ready_reg  <= 1'b1;
                    out_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    assign in_ready    = in_ready_reg;
    assign out_valid   = out_valid_reg;
    assign cmd.capture = in_valid && in_ready_reg;
    assign cmd.execute = (state_reg == S_EXEC);

endmodule

// ===== rtl/core/csa_dp.sv =====
// csa_dp: slot table, counters, config registers and result register
// depends on csa_pkg; sequenced by csa_ctrl

module csa_dp
    import csa_pkg::*;
#(
    parameter int unsigned MAX_SLOTS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  csa_cmd_t             cmd,
    input  logic [FUNC_W-1:0]    in_func,
    input  logic [SID_W-1:0]     in_slot_id,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_wdata,
    output csa_result_t          result
);

    logic [FUNC_W-1:0]    func_reg;
    logic [SID_W-1:0]     sid_reg;
    logic [MAX_SLOTS-1:0] active_reg, active_next;
    logic [SIZE_W-1:0]    size_reg, size_next;
    // active slots; slots at or above the size are always inactive
    logic [SIZE_W-1:0]    count_reg, count_next;
    logic [SIZE_W-1:0]    init_reg;
    logic [SIZE_W-1:0]    max_reg;
    csa_result_t          result_reg, result_next;

    logic [MAX_SLOTS-1:0] below_size;
    logic [MAX_SLOTS-1:0] free_vec;
    logic [MAX_SLOTS-1:0] lowest_free;
    logic [MAX_SLOTS-1:0] grow_onehot;
    logic [MAX_SLOTS-1:0] sid_onehot;
    logic [SIZE_W-1:0]    low_idx;
    logic [SIZE_W:0]      size_p1;
    logic                 have_free;
    logic                 grow_ok;
    logic                 init_ok;
    logic                 sid_in_old;
    logic                 sid_in_new;
    logic                 old_bit;
    logic [SIZE_W-1:0]    gidx;
    logic                 granted;
    status_t              status;

    always_comb
    begin
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            below_size[i]  = (i < int'(size_reg));
            grow_onehot[i] = (i == int'(size_reg));
            sid_onehot[i]  = (i == int'(sid_reg));
        end
    end

    // lowest free slot: isolate the lowest set bit, then encode it
    assign free_vec    = ~active_reg & below_size;
    assign lowest_free = free_vec & (~free_vec + MAX_SLOTS'(1));

    always_comb
    begin
        low_idx = '0;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            if (lowest_free[i])
            begin
                low_idx = low_idx | SIZE_W'(i);
            end
        end
    end

    assign have_free  = (count_reg < size_reg);
    assign size_p1    = {1'b0, size_reg} + (SIZE_W+1)'(1);
    assign grow_ok    = (size_p1 <= {1'b0, max_reg}) && (int'(size_p1) <= MAX_SLOTS);
    assign init_ok    = (init_reg != '0) && (max_reg != '0) && (init_reg <= max_reg)
                        && (int'(init_reg) <= MAX_SLOTS);
    assign sid_in_old = ({1'b0, sid_reg} < size_reg) && (int'(sid_reg) < MAX_SLOTS);
    assign old_bit    = |(active_reg & sid_onehot);

    always_comb
    begin
        active_next = active_reg;
        size_next   = size_reg;
        count_next  = count_reg;
        gidx        = '0;
        granted     = 1'b0;
        status      = STAT_OK;

        unique case (func_reg)
            FUNC_ALLOC:
            begin
                if (have_free)
                begin
                    active_next = active_reg | lowest_free;
                    gidx        = low_idx;
                    granted     = 1'b1;
                    count_next  = count_reg + SIZE_W'(1);
                end
                else if (grow_ok)
                begin
                    active_next = active_reg | grow_onehot;
                    gidx        = size_reg;
                    granted     = 1'b1;
                    size_next   = size_p1[SIZE_W-1:0];
                    count_next  = count_reg + SIZE_W'(1);
                end
                else
                begin
                    status = STAT_EXHAUSTED;
                end
            end
            FUNC_RELEASE:
            begin
                if (sid_in_old)
                begin
                    active_next = active_reg & ~sid_onehot;
                    count_next  = count_reg - SIZE_W'(old_bit);
                end
                else
                begin
                    status = STAT_RANGE;
                end
            end
            FUNC_CLEAR:
            begin
                active_next = '0;
                count_next  = '0;
            end
            FUNC_INIT:
            begin
                if (init_ok)
                begin
                    active_next = '0;
                    count_next  = '0;
                    size_next   = init_reg;
                end
                else
                begin
                    status = STAT_BAD_CONFIG;
                end
            end
            default:
            begin
                status = STAT_OK;
            end
        endcase

        sid_in_new = ({1'b0, sid_reg} < size_next) && (int'(sid_reg) < MAX_SLOTS);
        if (func_reg != FUNC_ALLOC && func_reg != FUNC_RELEASE &&
            func_reg != FUNC_CLEAR && func_reg != FUNC_INIT && !sid_in_new)
        begin
            status = STAT_RANGE;
        end

        result_next.granted     = granted;
        result_next.slot_index  = gidx[SID_W-1:0];
        result_next.slot_active = sid_in_new && (|(active_next & sid_onehot));
        result_next.slot_exists = sid_in_new;
        result_next.free_count  = size_next - count_next;
        result_next.pool_full   = (size_next == count_next);
        result_next.table_size  = size_next;
        result_next.status      = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            size_reg   <= '0;
            count_reg  <= '0;
            init_reg   <= INITIAL_COUNT_RST;
            max_reg    <= MAX_SLOTS_RST;
        end
        else
        begin
            if (cmd.execute)
            begin
                active_reg <= active_next;
                size_reg   <= size_next;
                count_reg  <= count_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_INITIAL_COUNT: init_reg <= cfg_wdata;
                    CFG_MAX_SLOTS:     max_reg  <= cfg_wdata;
                    default:           init_reg <= init_reg;
                endcase
            end
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= in_func;
            sid_reg  <= in_slot_id;
        end
        if (cmd.execute)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ===== rtl/core/connection_slot_allocator_top.sv =====
// Connection slot allocator: a table of up to MAX_SLOTS slots, each with an active bit,
// plus a current table size. An allocate grants the lowest free slot below the size, or
// grows the table by one slot up to max_slots; release, clear and initialize free slots.
// One item is handled at a time, as set by the single-entry controller sequence: it is taken,
// the table update and result are computed in the next cycle, and the result is offered in the
// cycle after that and held until the response side raises ready. Config writes go straight
// to the registers and are expected only while no item is in flight.

module connection_slot_allocator_top
    import csa_pkg::*;
#(
    parameter int unsigned MAX_SLOTS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_wdata,
    csa_req_if.sink              req,
    csa_rsp_if.source            rsp
);

    csa_cmd_t    cmd;
    csa_result_t result;

    csa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    csa_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_func    (req.func),
        .in_slot_id (req.slot_id),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .result     (result)
    );

    assign rsp.granted     = result.granted;
    assign rsp.slot_index  = result.slot_index;
    assign rsp.slot_active = result.slot_active;
    assign rsp.slot_exists = result.slot_exists;
    assign rsp.free_count  = result.free_count;
    assign rsp.pool_full   = result.pool_full;
    assign rsp.table_size  = result.table_size;
    assign rsp.status      = result.status;

endmodule

// ===== rtl/core/csa_checker.sv =====
// csa_checker: port-level properties of the connection slot allocator
// depends on csa_pkg; bound to connection_slot_allocator_top

module csa_checker
    import csa_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic                rsp_granted,
    input logic [SIZE_W-1:0]   rsp_free_count,
    input logic                rsp_pool_full,
    input logic [SIZE_W-1:0]   rsp_table_size,
    input logic [STATUS_W-1:0] rsp_status
);

    // a pending result is held until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before it was taken");

    // an accepted item blocks new requests, and its result is offered once the controller has left its execute state
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !rsp_valid && !req_ready ##1 rsp_valid)
        else $error("result not offered two cycles after accept");

    // one item in flight
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request taken while a result is pending");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_pool_full == (rsp_free_count == '0))
                      && (rsp_free_count <= rsp_table_size))
        else $error("free count inconsistent with full flag or size");

    a_grant: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_granted |-> rsp_status == STAT_OK)
        else $error("grant reported with error status");

endmodule

bind connection_slot_allocator_top csa_checker u_csa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_granted    (rsp.granted),
    .rsp_free_count (rsp.free_count),
    .rsp_pool_full  (rsp.pool_full),
    .rsp_table_size (rsp.table_size),
    .rsp_status     (rsp.status)
);

// ===== tb/tb_connection_slot_allocator_top.sv =====
// tb_connection_slot_allocator_top: self-checking bench for the connection slot allocator
// directed table, then phased random traffic, with results checked against listed values or an in-bench model
// depends on csa_pkg, csa_channels and connection_slot_allocator_top

module tb_connection_slot_allocator_top;
    import csa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SLOTS          = 64;
    localparam int unsigned N_PHASES       = 12;
    localparam int unsigned PHASE_ITEMS    = 154;
    localparam int unsigned IDLE_PCT       = 13;
    localparam int unsigned STALL_LIMIT    = 1000;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned STEADY_PHASE   = 4;
    localparam int unsigned PRESSURE_PHASE = 6;

    // codes with no enum member; the block treats them as a query
    localparam logic [FUNC_W-1:0] FUNC_SPARE_5 = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

    typedef struct {
        bit                 is_regs;
        logic [FUNC_W-1:0]  func;
        logic [SID_W-1:0]   sid;
        logic [SIZE_W-1:0]  ic;
        logic [SIZE_W-1:0]  ms;
        bit                 typed;
        csa_result_t        res;
    } slot_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_wdata;

    csa_req_if req_ch();
    csa_rsp_if rsp_ch();

    connection_slot_allocator_top #(.MAX_SLOTS(SLOTS)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // model of the pool
    logic [SLOTS-1:0]  slot_map;
    logic [SIZE_W-1:0] tbl_size;
    logic [SIZE_W-1:0] cfg_init;
    logic [SIZE_W-1:0] cfg_max;

    csa_result_t slot_results_due[$];
    slot_row_t   dir_rows[$];

    bit          steady;
    int unsigned mismatch_count;
    int unsigned n_requests;
    int unsigned n_results;
    int unsigned n_grants;
    int unsigned n_exhausted;
    int unsigned n_range;
    int unsigned n_bad_cfg;
    int unsigned peak_size;
    int unsigned quiet_cycles;

    function automatic csa_result_t result_of(bit g, int unsigned idx, bit act, bit ex,
                                              int unsigned nfree, bit full, int unsigned sz,
                                              status_t st);
        csa_result_t r;
        r.granted     = g;
        r.slot_index  = idx[SID_W-1:0];
        r.slot_active = act;
        r.slot_exists = ex;
        r.free_count  = nfree[SIZE_W-1:0];
        r.pool_full   = full;
        r.table_size  = sz[SIZE_W-1:0];
        r.status      = st;
        return r;
    endfunction

    function automatic slot_row_t req_row(logic [FUNC_W-1:0] f, logic [SID_W-1:0] s);
        slot_row_t row;
        row = '{is_regs: 1'b0, func: f, sid: s, ic: '0, ms: '0, typed: 1'b0, res: '0};
        return row;
    endfunction

    function automatic slot_row_t req_row_exp(logic [FUNC_W-1:0] f, logic [SID_W-1:0] s,
                                              csa_result_t r);
        slot_row_t row;
        row = '{is_regs: 1'b0, func: f, sid: s, ic: '0, ms: '0, typed: 1'b1, res: r};
        return row;
    endfunction

    function automatic slot_row_t regs_row(logic [SIZE_W-1:0] ic, logic [SIZE_W-1:0] ms);
        slot_row_t row;
        row = '{is_regs: 1'b1, func: '0, sid: '0, ic: ic, ms: ms, typed: 1'b0, res: '0};
        return row;
    endfunction

    // applies one request to the model and returns the result it should produce
    function automatic csa_result_t predict_slot_op(logic [FUNC_W-1:0] f,
                                                    logic [SID_W-1:0] s);
        csa_result_t r;
        bit          found;
        bit          exists;
        int unsigned nfree;
        r      = '0;
        found  = 1'b0;
        nfree  = 0;
        r.status = STAT_OK;
        case (f)
            FUNC_ALLOC:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!found && i < tbl_size && !slot_map[i])
                    begin
                        slot_map[i]  = 1'b1;
                        r.slot_index = i[SID_W-1:0];
                        found        = 1'b1;
                    end
                end
                // grow by one slot when every present slot is taken
                if (!found && int'(tbl_size) + 1 <= int'(cfg_max) &&
                    int'(tbl_size) + 1 <= SLOTS)
                begin
                    r.slot_index       = tbl_size[SID_W-1:0];
                    slot_map[tbl_size] = 1'b1;
                    tbl_size           = tbl_size + 1'b1;
                    found              = 1'b1;
                end
                if (!found)
                    r.status = STAT_EXHAUSTED;
            end
            FUNC_RELEASE:
            begin
                if (s < tbl_size)
                    slot_map[s] = 1'b0;
                else
                    r.status = STAT_RANGE;
            end
            FUNC_CLEAR:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (i < tbl_size)
                        slot_map[i] = 1'b0;
                end
            end
            FUNC_INIT:
            begin
                if (cfg_init != 0 && cfg_max != 0 && cfg_init <= cfg_max && cfg_init <= SLOTS)
                begin
                    tbl_size = cfg_init;
                    slot_map = '0;
                end
                else
                begin
                    r.status = STAT_BAD_CONFIG;
                end
            end
            default:
            begin
            end
        endcase
        exists = (s < tbl_size);
        if ((f == FUNC_QUERY || f > FUNC_INIT) && !exists)
            r.status = STAT_RANGE;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (i < tbl_size && !slot_map[i])
                nfree++;
        end
        r.granted     = found;
        r.slot_active = exists ? slot_map[s] : 1'b0;
        r.slot_exists = exists;
        r.free_count  = nfree[SIZE_W-1:0];
        r.pool_full   = (nfree == 0);
        r.table_size  = tbl_size;
        return r;
    endfunction

    task automatic send_req(logic [FUNC_W-1:0] f, logic [SID_W-1:0] s, bit typed,
                            csa_result_t typed_res);
        csa_result_t r;
        req_ch.valid   <= 1'b1;
        req_ch.func    <= f;
        req_ch.slot_id <= s;
        do
            @(posedge clk);
        while (!req_ch.ready);
        r = predict_slot_op(f, s);
        slot_results_due.push_back(typed ? typed_res : r);
        n_requests++;
        if (tbl_size > peak_size)
            peak_size = tbl_size;
    endtask

    // hold requests until every result is back, then let the pipeline empty
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (slot_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(logic [SIZE_W-1:0] ic, logic [SIZE_W-1:0] ms);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_INITIAL_COUNT;
        cfg_wdata <= ic;
        @(posedge clk);
        cfg_index <= CFG_MAX_SLOTS;
        cfg_wdata <= ms;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cfg_init  = ic;
        cfg_max   = ms;
    endtask

    task automatic flag_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // response side: random back-pressure except in the steady phase
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        csa_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            n_results++;
            if (rsp_ch.granted)
                n_grants++;
            case (rsp_ch.status)
                STAT_EXHAUSTED:  n_exhausted++;
                STAT_RANGE:      n_range++;
                STAT_BAD_CONFIG: n_bad_cfg++;
                default:
                begin
                end
            endcase
            if (slot_results_due.size() == 0)
            begin
                $display("%0t: result with no request outstanding", $time);
                mismatch_count++;
            end
            else
            begin
                want = slot_results_due.pop_front();
                flag_field("granted", want.granted, rsp_ch.granted);
                flag_field("slot_index", want.slot_index, rsp_ch.slot_index);
                flag_field("slot_active", want.slot_active, rsp_ch.slot_active);
                flag_field("slot_exists", want.slot_exists, rsp_ch.slot_exists);
                flag_field("free_count", want.free_count, rsp_ch.free_count);
                flag_field("pool_full", want.pool_full, rsp_ch.pool_full);
                flag_field("table_size", want.table_size, rsp_ch.table_size);
                flag_field("status", want.status, rsp_ch.status);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        logic [FUNC_W-1:0] f;
        logic [SID_W-1:0]  s;
        logic [SIZE_W-1:0] ic;
        logic [SIZE_W-1:0] ms;
        int unsigned       roll;
        bit                alloc_heavy;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_INITIAL_COUNT;
        cfg_wdata      = '0;
        req_ch.valid   = 1'b0;
        req_ch.func    = FUNC_QUERY;
        req_ch.slot_id = '0;
        steady         = 1'b0;
        mismatch_count = 0;
        n_requests     = 0;
        n_results      = 0;
        n_grants       = 0;
        n_exhausted    = 0;
        n_range        = 0;
        n_bad_cfg      = 0;
        peak_size      = 0;
        quiet_cycles   = 0;
        slot_map       = '0;
        tbl_size       = '0;
        cfg_init       = INITIAL_COUNT_RST;
        cfg_max        = MAX_SLOTS_RST;

        // after reset: initial_count 1, max_slots 64, empty table
        dir_rows.push_back(req_row_exp(FUNC_QUERY, 6'd0,
                           result_of(0, 0, 0, 0, 0, 1, 0, STAT_RANGE)));
        // allocate before any initialize grows the table from slot 0
        dir_rows.push_back(req_row_exp(FUNC_ALLOC, 6'd0,
                           result_of(1, 0, 1, 1, 0, 1, 1, STAT_OK)));
        dir_rows.push_back(req_row_exp(FUNC_ALLOC, 6'd63,
                           result_of(1, 1, 0, 0, 0, 1, 2, STAT_OK)));
        dir_rows.push_back(req_row_exp(FUNC_RELEASE, 6'd63,
                           result_of(0, 0, 0, 0, 0, 1, 2, STAT_RANGE)));
        dir_rows.push_back(req_row_exp(FUNC_RELEASE, 6'd0,
                           result_of(0, 0, 0, 1, 1, 0, 2, STAT_OK)));
        dir_rows.push_back(req_row_exp(FUNC_ALLOC, 6'd0,
                           result_of(1, 0, 1, 1, 0, 1, 2, STAT_OK)));
        dir_rows.push_back(req_row_exp(FUNC_SPARE_5, 6'd1,
                           result_of(0, 0, 1, 1, 0, 1, 2, STAT_OK)));
        dir_rows.push_back(req_row_exp(FUNC_SPARE_7, 6'd40,
                           result_of(0, 0, 0, 0, 0, 1, 2, STAT_RANGE)));
        dir_rows.push_back(req_row_exp(FUNC_SPARE_6, 6'd2,
                           result_of(0, 0, 0, 0, 0, 1, 2, STAT_RANGE)));
        dir_rows.push_back(req_row_exp(FUNC_CLEAR, 6'd1,
                           result_of(0, 0, 0, 1, 2, 0, 2, STAT_OK)));
        dir_rows.push_back(req_row_exp(FUNC_INIT, 6'd0,
                           result_of(0, 0, 0, 1, 1, 0, 1, STAT_OK)));
        // max_slots of zero: initialize refused, free slot still granted, no growth
        dir_rows.push_back(regs_row(7'd1, 7'd0));
        dir_rows.push_back(req_row_exp(FUNC_INIT, 6'd0,
                           result_of(0, 0, 0, 1, 1, 0, 1, STAT_BAD_CONFIG)));
        dir_rows.push_back(req_row_exp(FUNC_ALLOC, 6'd0,
                           result_of(1, 0, 1, 1, 0, 1, 1, STAT_OK)));
        dir_rows.push_back(req_row_exp(FUNC_ALLOC, 6'd0,
                           result_of(0, 0, 1, 1, 0, 1, 1, STAT_EXHAUSTED)));
        dir_rows.push_back(regs_row(7'd0, 7'd64));
        dir_rows.push_back(req_row_exp(FUNC_INIT, 6'd0,
                           result_of(0, 0, 1, 1, 0, 1, 1, STAT_BAD_CONFIG)));
        dir_rows.push_back(regs_row(7'd64, 7'd64));
        dir_rows.push_back(req_row_exp(FUNC_INIT, 6'd63,
                           result_of(0, 0, 0, 1, 64, 0, 64, STAT_OK)));
        dir_rows.push_back(regs_row(7'd100, 7'd64));
        dir_rows.push_back(req_row(FUNC_INIT, 6'd63));
        dir_rows.push_back(regs_row(7'd127, 7'd127));
        dir_rows.push_back(req_row(FUNC_INIT, 6'd0));
        dir_rows.push_back(regs_row(7'd2, 7'd3));
        dir_rows.push_back(req_row(FUNC_INIT, 6'd5));
        dir_rows.push_back(req_row(FUNC_ALLOC, 6'd1));
        dir_rows.push_back(req_row(FUNC_ALLOC, 6'd1));
        dir_rows.push_back(req_row(FUNC_ALLOC, 6'd2));
        dir_rows.push_back(req_row(FUNC_ALLOC, 6'd2));
        // maximum shrunk below the current size
        dir_rows.push_back(regs_row(7'd2, 7'd1));
        dir_rows.push_back(req_row(FUNC_RELEASE, 6'd1));
        dir_rows.push_back(req_row(FUNC_ALLOC, 6'd1));
        dir_rows.push_back(req_row(FUNC_ALLOC, 6'd0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_regs)
            begin
                settle();
                write_regs(dir_rows[i].ic, dir_rows[i].ms);
            end
            else
            begin
                send_req(dir_rows[i].func, dir_rows[i].sid, dir_rows[i].typed,
                         dir_rows[i].res);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            settle();
            case (ph)
                0: begin ic = 7'd1;   ms = 7'd64;  end
                1: begin ic = 7'd64;  ms = 7'd64;  end
                2: begin ic = 7'd1;   ms = 7'd1;   end
                3: begin ic = 7'd0;   ms = 7'd127; end
                4: begin ic = 7'd32;  ms = 7'd127; end
                5: begin ic = 7'd100; ms = 7'd0;   end
                default:
                begin
                    ic = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                                  : 7'($urandom_range(64, 1));
                    ms = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                                  : 7'($urandom_range(64, 1));
                end
            endcase
            write_regs(ic, ms);
            steady      = (ph == STEADY_PHASE);
            alloc_heavy = (ph % 2 == 1);
            send_req(FUNC_INIT, 6'($urandom_range(63)), 1'b0, '0);

            for (int n = 1; n < PHASE_ITEMS; n++)
            begin
                if (ph == PRESSURE_PHASE && n == PHASE_ITEMS / 2)
                    settle();
                else if (!steady && $urandom_range(99) < IDLE_PCT)
                begin
                    req_ch.valid <= 1'b0;
                    repeat ($urandom_range(5, 1)) @(posedge clk);
                end

                roll = $urandom_range(99);
                if (alloc_heavy)
                    f = (roll < 60) ? FUNC_ALLOC   :
                        (roll < 80) ? FUNC_RELEASE :
                        (roll < 90) ? FUNC_QUERY   :
                        (roll < 94) ? FUNC_INIT    :
                        (roll < 96) ? FUNC_CLEAR   : 3'($urandom_range(7, 5));
                else
                    f = (roll < 35) ? FUNC_ALLOC   :
                        (roll < 65) ? FUNC_RELEASE :
                        (roll < 85) ? FUNC_QUERY   :
                        (roll < 88) ? FUNC_INIT    :
                        (roll < 91) ? FUNC_CLEAR   : 3'($urandom_range(7, 5));

                // mostly slots that exist, some anywhere in the id space
                if (tbl_size != 0 && $urandom_range(99) < 80)
                    s = 6'($urandom_range(tbl_size - 1));
                else
                    s = 6'($urandom_range(63));
                send_req(f, s, 1'b0, '0);
            end
        end

        steady = 1'b0;
        settle();
        repeat (8) @(posedge clk);

        $display("%0d requests, %0d results: %0d grants, %0d exhausted, %0d out of range, %0d bad init",
                 n_requests, n_results, n_grants, n_exhausted, n_range, n_bad_cfg);
        $display("largest table size %0d, configs from zero to 127 incl. shrunken maximum",
                 peak_size);
        if (mismatch_count == 0 && slot_results_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
